/* src/mf3_pkg.sv */
// shared types and constants for the 3x3 median filter
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package mf3_pkg;

    localparam int MAX_WIDTH_DEF = 4096;
    localparam int MAX_HEIGHT    = 4096;

    localparam int CFG_W   = 13;
    localparam int PIX_W   = 8;
    localparam int COORD_W = 12;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

    localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // one full neighborhood plus the centre coordinates and end-of-frame flag
    typedef struct packed {
        logic [8:0][PIX_W-1:0] win;
        logic [COORD_W-1:0]    row;
        logic [COORD_W-1:0]    col;
        logic                  eof;
    } win_item_t;

    typedef struct packed {
        logic      valid;
        win_item_t item;
    } win_req_t;

endpackage

/* src/median_filter_3x3_unit.sv */
// top level of the 3x3 median filter: front end, window queue, sorting network
// depends on mf3_pkg, mf3_front, mf3_queue, mf3_sort
`timescale 1ns / 1ps

// Streams 8-bit grayscale pixels in raster order, one item per clock while
// s_tready is high, and returns the median of each interior 3x3 neighborhood
// together with its centre row and column; border pixels produce no item and are
// left to the consumer. tuser on the input marks the first pixel of a frame and
// restarts the counters; tlast on the output marks the last interior pixel.
// Sustained rate is one pixel per cycle when the output is not stalled, set by the
// single line buffer memory (one read and one write per cycle, both rows in one
// word) and the fully pipelined sorting network. A result passes from the intake
// registers through the window queue and the sort stages into the output register.
// The line buffers are not cleared after reset; the frame size registers may be
// written while the block is idle and take effect on the next pixel.
module median_filter_3x3_unit #(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [7:0] pixel
    input  logic                      s_tuser,   // [0] start_of_frame
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,   // [7:0] median, [19:8] centre_row,
                                                 // [31:20] centre_col
    output logic                      m_tlast,   // end_of_frame
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [0:0]                cfg_index, // 0 frame_width, 1 frame_height
    input  logic [mf3_pkg::CFG_W-1:0] cfg_data
);

    mf3_pkg::win_req_t            push, head;
    logic                         pop;
    logic [mf3_pkg::QCNT_W-1:0]   q_count;
    logic [mf3_pkg::PIX_W-1:0]    median;
    logic [mf3_pkg::COORD_W-1:0]  centre_row, centre_col;

    mf3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_count   (q_count),
        .push      (push)
    );

    mf3_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .count   (q_count)
    );

    mf3_sort u_sort (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (head),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .median       (median),
        .centre_row   (centre_row),
        .centre_col   (centre_col),
        .end_of_frame (m_tlast)
    );

    assign m_tdata = {centre_col, centre_row, median};

endmodule

/* src/mf3_front.sv */
// front end: pixel intake, frame counters, line buffer memory and 3x3 window
// depends on mf3_pkg; feeds complete windows to mf3_queue
`timescale 1ns / 1ps

module mf3_front #(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,     // [7:0] pixel
    input  logic                       s_tuser,     // [0] start_of_frame
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [0:0]                 cfg_index,
    input  logic [mf3_pkg::CFG_W-1:0]  cfg_data,
    input  logic [mf3_pkg::QCNT_W-1:0] q_count,
    output mf3_pkg::win_req_t          push
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int EW  = (CW + 1 > mf3_pkg::CFG_W) ? CW + 1 : mf3_pkg::CFG_W;
    localparam int CXW = (CW > mf3_pkg::COORD_W) ? CW : mf3_pkg::COORD_W;
    localparam int HW  = mf3_pkg::CFG_W;
    localparam int RW  = mf3_pkg::COORD_W;
    localparam int PW  = mf3_pkg::PIX_W;

    logic [HW-1:0] width_reg, height_reg;
    logic [EW-1:0] w_eff, w_ext;
    logic [HW-1:0] h_eff;

    logic [CW-1:0] col_reg, col_next, c_cur;
    logic [RW-1:0] row_reg, row_next, r_cur;
    logic          col_last, row_last, accept;

    logic          b_valid_reg;
    logic [PW-1:0] b_px_reg;
    logic [CW-1:0] b_col_reg;
    logic [RW-1:0] b_row_reg;
    logic          b_fwd_reg, b_fwd_next;

    logic [2*PW-1:0] lb_mem [MAX_WIDTH];
    logic [2*PW-1:0] lb_rd_reg, last_wr_reg, lb_line, lb_wr;
    logic [PW-1:0]   up_px, mid_px;

    logic [8:0][PW-1:0] win_reg, win_next;
    logic [CXW-1:0]     col_m1;
    logic               emit, eof;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= mf3_pkg::WIDTH_RST;
            height_reg <= mf3_pkg::HEIGHT_RST;
        end else if (cfg_valid) begin
            if (cfg_index == mf3_pkg::REG_FRAME_WIDTH) begin
                width_reg <= cfg_data;
            end else begin
                height_reg <= cfg_data;
            end
        end
    end

    always_comb begin
        w_ext = EW'(width_reg);
        if (w_ext < EW'(3)) begin
            w_eff = EW'(3);
        end else if (w_ext > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (height_reg < HW'(3)) begin
            h_eff = HW'(3);
        end else if (height_reg > HW'(mf3_pkg::MAX_HEIGHT)) begin
            h_eff = HW'(mf3_pkg::MAX_HEIGHT);
        end else begin
            h_eff = height_reg;
        end
    end

    // intake stage: counters and line buffer read
    assign s_tready = ((mf3_pkg::QCNT_W + 1)'(q_count) + (mf3_pkg::QCNT_W + 1)'(b_valid_reg))
                      < (mf3_pkg::QCNT_W + 1)'(mf3_pkg::QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;

    assign c_cur    = s_tuser ? '0 : col_reg;
    assign r_cur    = s_tuser ? '0 : row_reg;
    assign col_last = (EW'(c_cur) + EW'(1)) >= w_eff;
    assign row_last = (HW'(r_cur) + HW'(1)) >= h_eff;

    always_comb begin
        col_next = c_cur + CW'(1);
        row_next = r_cur;
        if (col_last) begin
            col_next = '0;
            row_next = row_last ? '0 : r_cur + RW'(1);
        end
    end

    // back-to-back items on the same column: take the write still in flight
    assign b_fwd_next = b_valid_reg && (b_col_reg == c_cur);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            b_valid_reg <= 1'b0;
            b_fwd_reg   <= 1'b0;
        end else begin
            b_valid_reg <= accept;
            b_fwd_reg   <= accept && b_fwd_next;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_px_reg  <= s_tdata;
            b_col_reg <= c_cur;
            b_row_reg <= r_cur;
        end
        if (b_valid_reg) begin
            last_wr_reg <= lb_wr;
        end
    end

    // line buffers: upper row in the high byte, middle row in the low byte
    always_ff @(posedge aclk) begin
        if (accept) begin
            lb_rd_reg <= lb_mem[c_cur];
        end
        if (b_valid_reg) begin
            lb_mem[b_col_reg] <= lb_wr;
        end
    end

    assign lb_line = b_fwd_reg ? last_wr_reg : lb_rd_reg;
    assign up_px   = lb_line[2*PW-1:PW];
    assign mid_px  = lb_line[PW-1:0];
    assign lb_wr   = {mid_px, b_px_reg};

    // window stage
    always_comb begin
        win_next      = win_reg;
        win_next[5:0] = win_reg[8:3];
        win_next[6]   = up_px;
        win_next[7]   = mid_px;
        win_next[8]   = b_px_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else if (b_valid_reg) begin
            win_reg <= win_next;
        end
    end

    assign col_m1 = CXW'(b_col_reg) - CXW'(1);
    assign emit   = b_valid_reg && (b_row_reg >= RW'(2)) && (b_col_reg >= CW'(2));
    assign eof    = (HW'(b_row_reg) == h_eff - HW'(1)) && (EW'(b_col_reg) == w_eff - EW'(1));

    always_comb begin
        push.valid    = emit;
        push.item.win = win_next;
        push.item.row = b_row_reg - RW'(1);
        push.item.col = col_m1[RW-1:0];
        push.item.eof = eof;
    end

endmodule

/* src/mf3_queue.sv */
// short window queue between the front end and the sorting network
// depends on mf3_pkg
`timescale 1ns / 1ps

module mf3_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  mf3_pkg::win_req_t          push,
    input  logic                       pop,
    output mf3_pkg::win_req_t          head,
    output logic [mf3_pkg::QCNT_W-1:0] count
);

    localparam int DEPTH = mf3_pkg::QUEUE_DEPTH;
    localparam int PW    = mf3_pkg::QPTR_W;
    localparam int NW    = mf3_pkg::QCNT_W;

    mf3_pkg::win_item_t q_mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0] count_reg, count_next;

    always_comb begin
        count_next = count_reg;
        if (push.valid && !pop) begin
            count_next = count_reg + NW'(1);
        end else if (!push.valid && pop) begin
            count_next = count_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push.valid) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push.valid) begin
            q_mem[wr_ptr_reg] <= push.item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = q_mem[rd_ptr_reg];
    assign count      = count_reg;

    // front end holds off intake early enough that the queue never overflows
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push.valid |-> count_reg < NW'(DEPTH))
        else $error("window queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("window queue underflow");

    a_push_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.valid && !pop) |=> head.valid)
        else $error("pushed item not visible at queue head");

endmodule

/* src/mf3_sort.sv */
// back end: pipelined median-of-nine network and output register
// depends on mf3_pkg; drains mf3_queue
`timescale 1ns / 1ps

module mf3_sort (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  mf3_pkg::win_req_t            head,
    output logic                         pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [mf3_pkg::PIX_W-1:0]    median,
    output logic [mf3_pkg::COORD_W-1:0]  centre_row,
    output logic [mf3_pkg::COORD_W-1:0]  centre_col,
    output logic                         end_of_frame
);

    localparam int PW = mf3_pkg::PIX_W;
    localparam int RW = mf3_pkg::COORD_W;

    function automatic logic [PW-1:0] min2(input logic [PW-1:0] a, input logic [PW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PW-1:0] max2(input logic [PW-1:0] a, input logic [PW-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [PW-1:0] med3(input logic [PW-1:0] a, input logic [PW-1:0] b,
                                           input logic [PW-1:0] c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    logic en;

    logic                  s1_valid_reg;
    logic [2:0][PW-1:0]    s1_lo_reg, s1_md_reg, s1_hi_reg;
    logic [RW-1:0]         s1_row_reg, s1_col_reg;
    logic                  s1_eof_reg;

    logic                  s2_valid_reg;
    logic [PW-1:0]         s2_l_reg, s2_m_reg, s2_h_reg;
    logic [RW-1:0]         s2_row_reg, s2_col_reg;
    logic                  s2_eof_reg;

    logic                  out_valid_reg;
    logic [PW-1:0]         out_med_reg;
    logic [RW-1:0]         out_row_reg, out_col_reg;
    logic                  out_eof_reg;

    assign en  = !out_valid_reg || m_tready;
    assign pop = en && head.valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg  <= head.valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // median of nine: sort each column, then max of lows, median of mids, min of highs, then median of those three
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                s1_lo_reg[k] <= min2(min2(head.item.win[3*k], head.item.win[3*k+1]),
                                     head.item.win[3*k+2]);
                s1_md_reg[k] <= med3(head.item.win[3*k], head.item.win[3*k+1],
                                     head.item.win[3*k+2]);
                s1_hi_reg[k] <= max2(max2(head.item.win[3*k], head.item.win[3*k+1]),
                                     head.item.win[3*k+2]);
            end
            s1_row_reg  <= head.item.row;
            s1_col_reg  <= head.item.col;
            s1_eof_reg  <= head.item.eof;

            s2_l_reg    <= max2(max2(s1_lo_reg[0], s1_lo_reg[1]), s1_lo_reg[2]);
            s2_m_reg    <= med3(s1_md_reg[0], s1_md_reg[1], s1_md_reg[2]);
            s2_h_reg    <= min2(min2(s1_hi_reg[0], s1_hi_reg[1]), s1_hi_reg[2]);
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
            s2_eof_reg  <= s1_eof_reg;

            out_med_reg <= med3(s2_l_reg, s2_m_reg, s2_h_reg);
            out_row_reg <= s2_row_reg;
            out_col_reg <= s2_col_reg;
            out_eof_reg <= s2_eof_reg;
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign median       = out_med_reg;
    assign centre_row   = out_row_reg;
    assign centre_col   = out_col_reg;
    assign end_of_frame = out_eof_reg;

endmodule
